[rtl/pdds_pkg.sv]
`timescale 1ns / 1ps
package pdds_pkg;

    localparam int PENDING_DEPTH = 1024;
    localparam int TX_BATCH      = 64;
    localparam int CMD_DEPTH     = 4;

    localparam int AW  = $clog2(PENDING_DEPTH);
    localparam int CW  = $clog2(PENDING_DEPTH + 1);
    localparam int SW  = $clog2(TX_BATCH + 1);
    localparam int QAW = $clog2(CMD_DEPTH);

    localparam logic [19:0] NS_PER_MS = 20'd1000000;

    localparam logic [0:0] REQ_ARRIVAL = 1'b0;
    localparam logic [0:0] REQ_POLL    = 1'b1;

    localparam logic [7:0] REG_LAG_MS     = 8'd0;
    localparam logic [7:0] REG_DROP_EVERY = 8'd1;

    typedef enum logic [2:0] {
        KIND_DROP   = 3'd0,
        KIND_QUEUED = 3'd1,
        KIND_TX     = 3'd2,
        KIND_IDLE   = 3'd3,
        KIND_FULL   = 3'd4
    } t_kind;

    typedef enum logic [1:0] {
        CMD_DROP,
        CMD_STORE,
        CMD_POLL
    } t_cmd_op;

    // tval is the due time for a store and the poll time for a poll
    typedef struct packed {
        t_cmd_op     op;
        logic [63:0] tval;
        logic [23:0] addr;
        logic [12:0] len;
        logic [10:0] space;
    } t_cmd;

    typedef struct packed {
        logic [12:0] len;
        logic [23:0] addr;
        logic [63:0] due;
    } t_entry;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_SCAN_RD,
        ST_SCAN_EV,
        ST_MOVE_RD,
        ST_MOVE_WR,
        ST_FINISH
    } t_back_state;

endpackage

[rtl/pdds_ram.sv]
`timescale 1ns / 1ps
module pdds_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;
endmodule

[rtl/pdds_front.sv]
`timescale 1ns / 1ps
module pdds_front
    import pdds_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    input  logic [7:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [0:0]  i_req_type,
    input  logic [63:0] i_now_time,
    input  logic [23:0] i_frame_addr,
    input  logic [12:0] i_frame_len,
    input  logic [10:0] i_tx_space,
    output logic        o_push,
    output t_cmd        o_cmd,
    input  logic        i_full
);
    logic [15:0] r_lag_ms, r_drop_every, r_phase, n_phase;
    logic        r_hold_vld;
    t_cmd        r_hold;
    logic [35:0] r_prod;
    logic        accept, is_drop;
    logic [15:0] phase_inc;

    assign o_push  = r_hold_vld && !i_full;
    assign o_ready = !r_hold_vld || o_push;
    assign accept  = i_valid && o_ready;

    // periodic drop decision
    always_comb begin
        phase_inc = r_phase + 16'd1;
        is_drop   = 1'b0;
        n_phase   = r_phase;
        if (r_drop_every != 16'd0) begin
            if (phase_inc >= r_drop_every) begin
                is_drop = 1'b1;
                n_phase = 16'd0;
            end else begin
                n_phase = phase_inc;
            end
        end
    end

    always_comb begin
        o_cmd = r_hold;
        if (r_hold.op == CMD_STORE) begin
            o_cmd.tval = r_hold.tval + {28'd0, r_prod};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lag_ms     <= 16'd10;
            r_drop_every <= 16'd10;
            r_phase      <= 16'd0;
            r_hold_vld   <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                if (i_cfg_index == REG_LAG_MS) begin
                    r_lag_ms <= i_cfg_data;
                end else if (i_cfg_index == REG_DROP_EVERY) begin
                    r_drop_every <= i_cfg_data;
                end
            end
            if (accept) begin
                r_hold_vld <= 1'b1;
                if (i_req_type == REQ_ARRIVAL) begin
                    r_phase <= n_phase;
                end
            end else if (o_push) begin
                r_hold_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_prod       <= r_lag_ms * NS_PER_MS;
            r_hold.tval  <= i_now_time;
            r_hold.addr  <= i_frame_addr;
            r_hold.len   <= i_frame_len;
            r_hold.space <= i_tx_space;
            if (i_req_type == REQ_POLL) begin
                r_hold.op <= CMD_POLL;
            end else if (is_drop) begin
                r_hold.op <= CMD_DROP;
            end else begin
                r_hold.op <= CMD_STORE;
            end
        end
    end
endmodule

[rtl/pdds_cmd_fifo.sv]
`timescale 1ns / 1ps
module pdds_cmd_fifo
    import pdds_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output t_cmd o_cmd,
    output logic o_empty
);
    t_cmd           r_mem [CMD_DEPTH];
    logic [QAW-1:0] r_wr, r_rd;
    logic [QAW:0]   r_cnt;

    assign o_full  = r_cnt == (QAW+1)'(CMD_DEPTH);
    assign o_empty = r_cnt == '0;
    assign o_cmd   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end
endmodule

[rtl/pdds_back.sv]
`timescale 1ns / 1ps
module pdds_back
    import pdds_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_empty,
    input  t_cmd        i_cmd,
    output logic        o_pop,
    output logic        o_valid,
    input  logic        i_ready,
    output t_kind       o_kind,
    output logic [23:0] o_addr,
    output logic [12:0] o_len,
    output logic        o_last
);
    t_back_state r_state, n_state;
    t_cmd        r_cmd;
    logic [CW-1:0] r_count, r_idx;
    logic [SW-1:0] r_sent, r_limit, lim;
    logic [CW-1:0] min_cs;
    logic          r_pend_vld;
    t_entry        r_pend, rd_data, wr_data;
    logic          wr_en, out_free, out_load, due_hit, full;
    logic [AW-1:0] wr_addr, rd_addr;
    t_kind         ld_kind;
    logic [23:0]   ld_addr;
    logic [12:0]   ld_len;
    logic          ld_last;
    logic          r_out_vld, r_out_last;
    t_kind         r_out_kind;
    logic [23:0]   r_out_addr;
    logic [12:0]   r_out_len;

    pdds_ram #(.WIDTH($bits(t_entry)), .DEPTH(PENDING_DEPTH)) u_table (
        .i_clk    (i_clk),
        .i_wr_en  (wr_en),
        .i_wr_addr(wr_addr),
        .i_wr_data(wr_data),
        .i_rd_addr(rd_addr),
        .o_rd_data(rd_data)
    );

    assign out_free = !r_out_vld || i_ready;
    assign due_hit  = rd_data.due <= r_cmd.tval;
    assign full     = r_count >= CW'(PENDING_DEPTH);
    assign min_cs   = (r_count < CW'(r_cmd.space)) ? r_count : CW'(r_cmd.space);
    assign lim      = (min_cs > CW'(TX_BATCH)) ? SW'(TX_BATCH) : min_cs[SW-1:0];

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (!i_empty) n_state = ST_DISPATCH;
            ST_DISPATCH: begin
                if (r_cmd.op == CMD_POLL) begin
                    n_state = (lim == '0) ? ST_FINISH : ST_SCAN_RD;
                end else if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            ST_SCAN_RD: n_state = ST_SCAN_EV;
            ST_SCAN_EV: begin
                if (due_hit) begin
                    if (!r_pend_vld || out_free) n_state = ST_MOVE_RD;
                end else begin
                    n_state = (r_idx + 1'b1 < r_count) ? ST_SCAN_RD : ST_FINISH;
                end
            end
            ST_MOVE_RD: n_state = ST_MOVE_WR;
            ST_MOVE_WR: begin
                n_state = (r_idx < r_count && r_sent < r_limit) ? ST_SCAN_RD : ST_FINISH;
            end
            ST_FINISH: if (out_free) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_pop    = 1'b0;
        wr_en    = 1'b0;
        wr_addr  = r_idx[AW-1:0];
        wr_data  = rd_data;
        rd_addr  = r_idx[AW-1:0];
        out_load = 1'b0;
        ld_kind  = KIND_TX;
        ld_addr  = r_pend.addr;
        ld_len   = r_pend.len;
        ld_last  = 1'b0;
        unique case (r_state)
            ST_IDLE: o_pop = !i_empty;
            ST_DISPATCH: begin
                ld_addr = r_cmd.addr;
                ld_len  = r_cmd.len;
                ld_last = 1'b1;
                if (r_cmd.op == CMD_DROP) begin
                    ld_kind = KIND_DROP;
                end else if (full) begin
                    ld_kind = KIND_FULL;
                end else begin
                    ld_kind = KIND_QUEUED;
                end
                if (r_cmd.op != CMD_POLL) begin
                    out_load = out_free;
                end
                wr_en   = (r_cmd.op == CMD_STORE) && !full && out_free;
                wr_addr = r_count[AW-1:0];
                wr_data = '{len: r_cmd.len, addr: r_cmd.addr, due: r_cmd.tval};
            end
            ST_SCAN_EV: out_load = due_hit && r_pend_vld && out_free;
            ST_MOVE_RD: rd_addr = r_count[AW-1:0];
            ST_MOVE_WR: begin
                rd_addr = r_count[AW-1:0];
                wr_en   = 1'b1;
            end
            ST_FINISH: begin
                out_load = out_free;
                ld_last  = 1'b1;
                if (!r_pend_vld) begin
                    ld_kind = KIND_IDLE;
                    ld_addr = '0;
                    ld_len  = '0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_count    <= '0;
            r_out_vld  <= 1'b0;
            r_pend_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_out_vld <= 1'b1;
            end else if (i_ready) begin
                r_out_vld <= 1'b0;
            end
            if (r_state == ST_DISPATCH) begin
                r_pend_vld <= 1'b0;
                if (wr_en) r_count <= r_count + 1'b1;
            end
            if (r_state == ST_SCAN_EV && n_state == ST_MOVE_RD) begin
                r_pend_vld <= 1'b1;
                r_count    <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd <= i_cmd;
        end
        if (r_state == ST_DISPATCH) begin
            r_idx   <= '0;
            r_sent  <= '0;
            r_limit <= lim;
        end
        if (r_state == ST_SCAN_EV) begin
            if (n_state == ST_MOVE_RD) begin
                r_pend <= rd_data;
                r_sent <= r_sent + 1'b1;
            end else if (!due_hit) begin
                r_idx <= r_idx + 1'b1;
            end
        end
        if (out_load) begin
            r_out_kind <= ld_kind;
            r_out_addr <= ld_addr;
            r_out_len  <= ld_len;
            r_out_last <= ld_last;
        end
    end

    assign o_valid = r_out_vld;
    assign o_kind  = r_out_kind;
    assign o_addr  = r_out_addr;
    assign o_len   = r_out_len;
    assign o_last  = r_out_last;
endmodule

[rtl/packet_delay_drop_shaper_top.sv]
`timescale 1ns / 1ps
// fixed-delay, periodic-drop packet shaper. an arrival (tuser 0) is either
// dropped as every nth arrival, refused when the 1024-entry pending table is
// full, or stored with due time now + lag_ms * 1e6 ns; each arrival gives
// one result transfer. a poll (tuser 1) scans the table from entry 0 and sends
// up to min(count, 64, tx_space) due frames, filling each hole with the last
// entry; it gives one transfer per sent frame, or a single "nothing due"
// transfer, tlast on the final one. the front stage takes one item per cycle
// into a four-deep command queue unless it is full; the back end answers an
// arrival and, per poll, reads each entry looked at and moves the last entry
// into each sent frame's hole (registered table read, then the refill write)
// and waits on a stalled result side. no clearing pass after reset is needed
module packet_delay_drop_shaper_top
    import pdds_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    // configuration: index 0 lag_ms, index 1 drop_every
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [7:0]   i_cfg_index,
    input  logic [15:0]  i_cfg_data,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // tdata: now_time[63:0], frame_addr[87:64], frame_len[100:88], tx_space[111:101]
    input  logic [111:0] i_s_axis_tdata,
    // tuser: req_type
    input  logic [0:0]   i_s_axis_tuser,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // tdata: out_addr[23:0], out_len[36:24], zero fill up to 40 bits
    output logic [39:0]  o_m_axis_tdata,
    // tuser: kind
    output logic [2:0]   o_m_axis_tuser,
    output logic         o_m_axis_tlast
);
    logic  push, full, pop, empty;
    t_cmd  cmd_in, cmd_out;
    t_kind kind;
    logic [23:0] addr;
    logic [12:0] len;

    // registers are written whenever asked; the block is idle by contract
    assign o_cfg_ready = 1'b1;

    pdds_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_s_axis_tvalid),
        .o_ready     (o_s_axis_tready),
        .i_req_type  (i_s_axis_tuser),
        .i_now_time  (i_s_axis_tdata[63:0]),
        .i_frame_addr(i_s_axis_tdata[87:64]),
        .i_frame_len (i_s_axis_tdata[100:88]),
        .i_tx_space  (i_s_axis_tdata[111:101]),
        .o_push      (push),
        .o_cmd       (cmd_in),
        .i_full      (full)
    );

    pdds_cmd_fifo u_fifo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_cmd  (cmd_in),
        .o_full (full),
        .i_pop  (pop),
        .o_cmd  (cmd_out),
        .o_empty(empty)
    );

    pdds_back u_back (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_empty(empty),
        .i_cmd  (cmd_out),
        .o_pop  (pop),
        .o_valid(o_m_axis_tvalid),
        .i_ready(i_m_axis_tready),
        .o_kind (kind),
        .o_addr (addr),
        .o_len  (len),
        .o_last (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = {3'b000, len, addr};
    assign o_m_axis_tuser = kind;
endmodule

[sim/pdds_checker.sv]
`timescale 1ns / 1ps
module pdds_checker
    import pdds_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_valid,
    input  logic         i_cfg_ready,
    input  logic [7:0]   i_cfg_index,
    input  logic [15:0]  i_cfg_data,
    input  logic         i_s_tvalid,
    input  logic         i_s_tready,
    input  logic [111:0] i_s_tdata,
    input  logic [0:0]   i_s_tuser,
    input  logic         i_m_tvalid,
    input  logic         i_m_tready,
    input  logic [39:0]  i_m_tdata,
    input  logic [2:0]   i_m_tuser,
    input  logic         i_m_tlast,
    output int           o_pending,
    output int           o_fail_count
);

    typedef struct {
        t_kind       kind;
        logic [23:0] addr;
        logic [12:0] len;
        logic        last;
    } t_frame_result;

    t_frame_result expected_results[$];

    logic [63:0] tbl_due  [PENDING_DEPTH];
    logic [23:0] tbl_addr [PENDING_DEPTH];
    logic [12:0] tbl_len  [PENDING_DEPTH];
    int          tbl_count;
    logic [15:0] phase_cnt;
    logic [15:0] lag_ms_reg;
    logic [15:0] drop_every_reg;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    task automatic report(input string what);
        $display("checker: mismatch at %0t: %s", $realtime, what);
        o_fail_count++;
    endtask

    function automatic t_frame_result mk(t_kind k, logic [23:0] a, logic [12:0] l, logic t);
        t_frame_result r;
        r.kind = k;
        r.addr = a;
        r.len  = l;
        r.last = t;
        return r;
    endfunction

    // works out the results of one input transfer and updates the table
    task automatic shaper_predict(input logic [0:0] req, input logic [111:0] d);
        logic [63:0] now;
        logic [23:0] addr;
        logic [12:0] len;
        logic [10:0] space;
        int          lim;
        int          i;
        int          sent;
        now   = d[63:0];
        addr  = d[87:64];
        len   = d[100:88];
        space = d[111:101];
        if (req == REQ_ARRIVAL) begin
            if (drop_every_reg != 0) begin
                phase_cnt = phase_cnt + 16'd1;
                if (phase_cnt >= drop_every_reg) begin
                    phase_cnt = 0;
                    expected_results.push_back(mk(KIND_DROP, addr, len, 1'b1));
                    return;
                end
            end
            if (tbl_count >= PENDING_DEPTH) begin
                expected_results.push_back(mk(KIND_FULL, addr, len, 1'b1));
                return;
            end
            tbl_due[tbl_count]  = now + 64'(lag_ms_reg) * 64'd1000000;
            tbl_addr[tbl_count] = addr;
            tbl_len[tbl_count]  = len;
            tbl_count++;
            expected_results.push_back(mk(KIND_QUEUED, addr, len, 1'b1));
        end else begin
            lim = tbl_count;
            if (lim > TX_BATCH) lim = TX_BATCH;
            if (lim > int'(space)) lim = int'(space);
            i = 0;
            sent = 0;
            while (i < tbl_count && sent < lim) begin
                if (tbl_due[i] > now) begin
                    i++;
                end else begin
                    expected_results.push_back(mk(KIND_TX, tbl_addr[i], tbl_len[i], 1'b0));
                    sent++;
                    tbl_count--;
                    tbl_due[i]  = tbl_due[tbl_count];
                    tbl_addr[i] = tbl_addr[tbl_count];
                    tbl_len[i]  = tbl_len[tbl_count];
                end
            end
            if (sent == 0)
                expected_results.push_back(mk(KIND_IDLE, '0, '0, 1'b1));
            else
                expected_results[$].last = 1'b1;
        end
    endtask

    always @(posedge i_clk) begin
        t_frame_result e;
        if (!i_rst_n) begin
            tbl_count      = 0;
            phase_cnt      = 0;
            lag_ms_reg     = 16'd10;
            drop_every_reg = 16'd10;
            expected_results.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == REG_LAG_MS) lag_ms_reg = i_cfg_data;
                else if (i_cfg_index == REG_DROP_EVERY) drop_every_reg = i_cfg_data;
            end
            if (i_s_tvalid && i_s_tready)
                shaper_predict(i_s_tuser, i_s_tdata);
            if (i_m_tvalid && i_m_tready) begin
                if (expected_results.size() == 0) begin
                    report($sformatf("unexpected result kind %0d", i_m_tuser));
                end else begin
                    e = expected_results.pop_front();
                    if (i_m_tuser !== e.kind)
                        report($sformatf("kind %0d, want %0d", i_m_tuser, e.kind));
                    if (i_m_tdata[23:0] !== e.addr)
                        report($sformatf("addr %h, want %h", i_m_tdata[23:0], e.addr));
                    if (i_m_tdata[36:24] !== e.len)
                        report($sformatf("len %0d, want %0d", i_m_tdata[36:24], e.len));
                    if (i_m_tlast !== e.last)
                        report($sformatf("last %b, want %b", i_m_tlast, e.last));
                end
            end
        end
        o_pending = expected_results.size();
    end

endmodule

[sim/testbench.sv]
`timescale 1ns / 1ps
module testbench;
    import pdds_pkg::*;

    // cycles with no transfer on any channel before the run is called hung
    localparam int WATCHDOG_LIMIT = 40000;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [7:0]   cfg_index = '0;
    logic [15:0]  cfg_data = '0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [111:0] s_tdata = '0;
    logic [0:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [39:0]  m_tdata;
    logic [2:0]   m_tuser;
    logic         m_tlast;

    int          pending;
    int          fail_count;
    int          idle_cycles = 0;
    bit          quiet = 1'b0;    // no idling on either side while set
    logic [63:0] clock_ns = 64'd5000000000;
    logic [15:0] cur_delay = 16'd10;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    packet_delay_drop_shaper_top u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser),
        .o_m_axis_tlast  (m_tlast)
    );

    pdds_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tuser    (m_tuser),
        .i_m_tlast    (m_tlast),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    // watchdog: any transfer on any channel restarts the count
    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // result side: random stall before each transfer, tready held while waiting
    initial begin
        int stall;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            stall = quiet ? 0 : $urandom_range(0, 16);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_tready <= 1'b1;
            @(posedge i_clk);
            while (!m_tvalid) @(posedge i_clk);
        end
    end

    // one input transfer; valid stays up when the next item follows at once
    task automatic send_item(input logic [0:0] req, input logic [63:0] now,
                             input logic [23:0] addr, input logic [12:0] len,
                             input logic [10:0] space);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {space, len, addr, now};
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
    endtask

    // hold the input side until every outstanding result has been seen
    task automatic drain();
        s_tvalid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [7:0] idx, input logic [15:0] val);
        drain();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
        cfg_valid <= 1'b0;
        if (idx == REG_LAG_MS) cur_delay = val;
    endtask

    task automatic arrive(input logic [63:0] now);
        send_item(REQ_ARRIVAL, now, 24'($urandom), 13'($urandom), 11'($urandom));
    endtask

    task automatic poll(input logic [63:0] now, input logic [10:0] space);
        send_item(REQ_POLL, now, 24'($urandom), 13'($urandom), space);
    endtask

    // mostly arrivals and polls around a moving clock, polls reaching
    // sometimes short of and sometimes past the current delay
    task automatic random_phase(input int n_items);
        logic [63:0] span;
        logic [63:0] t_poll;
        logic [10:0] space;
        int          sel;
        for (int k = 0; k < n_items; k++) begin
            span = 64'(cur_delay) * 64'd1000000;
            clock_ns = clock_ns + 64'($urandom_range(0, 3000000));
            if (k == n_items / 2) drain();
            if ($urandom_range(0, 99) < 55) begin
                arrive(clock_ns);
            end else begin
                sel = $urandom_range(0, 9);
                if (sel < 4)      t_poll = clock_ns + span;
                else if (sel < 7) t_poll = clock_ns + (span >> 1);
                else if (sel < 9) t_poll = clock_ns;
                else              t_poll = '1;
                sel = $urandom_range(0, 9);
                if (sel == 0)     space = 11'd0;
                else if (sel < 6) space = 11'($urandom_range(1, 8));
                else if (sel < 8) space = 11'($urandom_range(9, 1024));
                else              space = 11'($urandom);
                poll(t_poll, space);
            end
        end
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty poll, field extremes, periodic drop every third
        poll(64'd0, 11'd5);
        write_reg(REG_LAG_MS, 16'd0);
        write_reg(REG_DROP_EVERY, 16'd3);
        send_item(REQ_ARRIVAL, 64'd0, 24'h000000, 13'h0000, 11'h000);
        send_item(REQ_ARRIVAL, '1, 24'hFFFFFF, 13'h1FFF, 11'h7FF);
        send_item(REQ_ARRIVAL, 64'd7, 24'hA5A5A5, 13'h0AAA, 11'h555);
        poll(64'd0, 11'd0);
        poll(64'd0, 11'd1);
        poll('1, 11'h7FF);
        poll('1, 11'd64);
        // threshold lowered below the running phase
        arrive(64'd100);
        arrive(64'd101);
        write_reg(REG_DROP_EVERY, 16'd1);
        arrive(64'd102);
        // dropping off, due time wrapping past the top of the time range
        write_reg(REG_DROP_EVERY, 16'd0);
        write_reg(REG_LAG_MS, 16'hFFFF);
        arrive(64'hFFFF_FFFF_FFFF_FFF0);
        arrive(64'hFFFF_FFFF_0000_0000);
        poll(64'd0, 11'd8);
        poll(64'hFFFF_FFFF_FFFF_FFFF, 11'd8);
        poll(64'h0000_0010_0000_0000, 11'd8);

        // random phases over a spread of register settings
        write_reg(REG_LAG_MS, 16'd2);
        write_reg(REG_DROP_EVERY, 16'd7);
        random_phase(120);
        write_reg(REG_LAG_MS, 16'd0);
        write_reg(REG_DROP_EVERY, 16'hFFFF);
        quiet = 1'b1;
        random_phase(100);
        quiet = 1'b0;
        write_reg(REG_LAG_MS, 16'hFFFF);
        write_reg(REG_DROP_EVERY, 16'd1);
        random_phase(40);
        write_reg(REG_DROP_EVERY, 16'd0);
        random_phase(60);
        write_reg(REG_LAG_MS, 16'($urandom_range(1, 20)));
        write_reg(REG_DROP_EVERY, 16'($urandom_range(2, 12)));
        random_phase(134);

        drain();
        repeat (50) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
